FILE: sv/costmap_rotate_fuse_grid_assert.svh
// assertion macros for the costmap fusion block checker
// no dependencies; included by the checker file only
`ifndef COSTMAP_ROTATE_FUSE_GRID_ASSERT_SVH
`define COSTMAP_ROTATE_FUSE_GRID_ASSERT_SVH

// condition holds in the cycle after the trigger
`define CRFG_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("crfg check failed");

// condition holds in the same cycle as the trigger
`define CRFG_ASSERT_SAME(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("crfg check failed");

`endif

FILE: sv/crfg_pkg.sv
// shared types and constants for the costmap fusion block
// no dependencies
package crfg_pkg;

    // request commands
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_INTEG = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_GWIDTH  = 3'd0;
    localparam logic [2:0] REG_GHEIGHT = 3'd1;
    localparam logic [2:0] REG_GRES    = 3'd2;
    localparam logic [2:0] REG_GORGX   = 3'd3;
    localparam logic [2:0] REG_GORGY   = 3'd4;
    localparam logic [2:0] REG_LWIDTH  = 3'd5;
    localparam logic [2:0] REG_LHEIGHT = 3'd6;
    localparam logic [2:0] REG_LRES    = 3'd7;

    // width of the shared arithmetic unit
    localparam int ALU_W = 64;

    typedef logic signed [ALU_W-1:0] t_word;

    // operation request to the shared unit
    typedef struct packed {
        logic go;
        logic op_div;
    } t_alu_req;

endpackage

FILE: sv/crfg_alu.sv
// shared iterative unit: shift-add multiply by a 16-bit signed factor,
// and floor division by a positive divisor, one bit per cycle
// depends on crfg_pkg
module crfg_alu import crfg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    input  t_word    i_a,
    input  t_word    i_b,
    output logic     o_done,
    output t_word    o_res
);

    logic              r_busy;
    logic              r_div;
    logic              r_done;
    logic              r_neg;
    logic [5:0]        r_cnt;
    t_word             r_acc;
    t_word             r_opa;
    logic [15:0]       r_m;
    logic [ALU_W:0]    r_rem;
    logic [ALU_W-1:0]  r_quo;
    logic [ALU_W-1:0]  r_den;

    logic [ALU_W:0]    rem_sh;
    logic              fits;
    logic              last;
    logic [ALU_W-1:0]  mag;

    // trial subtract for the divide step
    assign rem_sh = {r_rem[ALU_W-1:0], r_quo[ALU_W-1]};
    assign fits   = (rem_sh >= {1'b0, r_den});
    assign last   = r_div ? (r_cnt == 6'd63) : (r_cnt == 6'd15);
    // floor of a negative dividend via the ceiling of its magnitude
    assign mag    = i_a[ALU_W-1] ? (ALU_W'(-i_a) + ALU_W'(i_b) - ALU_W'(1))
                                 : ALU_W'(i_a);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_div <= i_req.op_div;
            r_neg <= i_a[ALU_W-1];
            r_acc <= '0;
            r_opa <= i_a;
            r_m   <= i_b[15:0];
            r_rem <= '0;
            r_quo <= mag;
            r_den <= ALU_W'(i_b);
        end else if (r_busy) begin
            if (r_div) begin
                r_rem <= fits ? (rem_sh - {1'b0, r_den}) : rem_sh;
                r_quo <= {r_quo[ALU_W-2:0], fits};
            end else begin
                // top bit of the factor carries negative weight
                if (r_m[0]) begin
                    r_acc <= (r_cnt == 6'd15) ? (r_acc - r_opa) : (r_acc + r_opa);
                end
                r_opa <= r_opa <<< 1;
                r_m   <= {1'b0, r_m[15:1]};
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_div ? (r_neg ? -$signed(r_quo) : $signed(r_quo)) : r_acc;

endmodule

FILE: sv/costmap_rotate_fuse_grid.sv
// top level: configuration, sequencer, global grid and costmap memories
// depends on crfg_pkg and crfg_alu
//
// channel    direction  handshake                    payload
// request    in         start high, busy low         i_command .. i_local_origin_y
// result     out        o_valid one cycle, no stall  o_read_value
// config     in         i_cfg_valid and o_cfg_ready  i_cfg_index, i_cfg_data
//
// load writes a costmap cell; read: result in the last state, S_RD2, and only for an
// index inside the grid; clear writes every grid cell. integrate runs its setup and
// then each grid cell in the box, with extra steps for a cell that hits the costmap,
// all through the one shared multiply/divide unit.
// after reset a clearing pass over all GLOBAL_SIDE*GLOBAL_SIDE grid cells runs with busy high.
// the result cannot be stalled; configuration writes are taken at any time.
module costmap_rotate_fuse_grid import crfg_pkg::*; #(
    parameter int GLOBAL_SIDE = 256,
    parameter int LOCAL_SIDE  = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_command,
    input  logic [15:0]        i_cell_index,
    input  logic signed [7:0]  i_cell_value,
    input  logic signed [31:0] i_pose_x,
    input  logic signed [31:0] i_pose_y,
    input  logic signed [15:0] i_pose_cos,
    input  logic signed [15:0] i_pose_sin,
    input  logic signed [31:0] i_local_origin_x,
    input  logic signed [31:0] i_local_origin_y,
    output logic               o_valid,
    output logic signed [7:0]  o_read_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int GD_W = $clog2(GLOBAL_SIDE + 1);
    localparam int LD_W = $clog2(LOCAL_SIDE + 1);
    localparam int GA_W = $clog2(GLOBAL_SIDE * GLOBAL_SIDE);
    localparam int LA_W = $clog2(LOCAL_SIDE * LOCAL_SIDE);

    // sequencer states
    localparam logic [5:0] S_IDLE = 6'd0;
    localparam logic [5:0] S_CLR  = 6'd1;
    localparam logic [5:0] S_PREP = 6'd2;
    localparam logic [5:0] S_LOAD = 6'd3;
    localparam logic [5:0] S_RD   = 6'd4;
    localparam logic [5:0] S_RD2  = 6'd5;
    localparam logic [5:0] S_WAIT = 6'd6;
    localparam logic [5:0] I_A    = 6'd7;
    localparam logic [5:0] I_B    = 6'd8;
    localparam logic [5:0] I_C    = 6'd9;
    localparam logic [5:0] I_D    = 6'd10;
    localparam logic [5:0] I_E    = 6'd11;
    localparam logic [5:0] I_F    = 6'd12;
    localparam logic [5:0] I_G    = 6'd13;
    localparam logic [5:0] I_H    = 6'd14;
    localparam logic [5:0] I_J    = 6'd15;
    localparam logic [5:0] I_K    = 6'd16;
    localparam logic [5:0] I_L    = 6'd17;
    localparam logic [5:0] I_M    = 6'd18;
    localparam logic [5:0] I_N    = 6'd19;
    localparam logic [5:0] C_A    = 6'd20;
    localparam logic [5:0] C_B    = 6'd21;
    localparam logic [5:0] C_C    = 6'd22;
    localparam logic [5:0] C_D    = 6'd23;
    localparam logic [5:0] C_E    = 6'd24;
    localparam logic [5:0] C_F    = 6'd25;
    localparam logic [5:0] C_G    = 6'd26;
    localparam logic [5:0] C_H    = 6'd27;
    localparam logic [5:0] C_I    = 6'd28;
    localparam logic [5:0] C_J    = 6'd29;
    localparam logic [5:0] C_K    = 6'd30;
    localparam logic [5:0] C_L    = 6'd31;
    localparam logic [5:0] C_N    = 6'd32;

    // configuration registers
    logic [8:0]         r_gwidth;
    logic [8:0]         r_gheight;
    logic [30:0]        r_gres;
    logic signed [31:0] r_gorgx;
    logic signed [31:0] r_gorgy;
    logic [7:0]         r_lwidth;
    logic [7:0]         r_lheight;
    logic [30:0]        r_lres;

    // latched request
    logic [1:0]         r_cmd;
    logic [15:0]        r_idx;
    logic signed [7:0]  r_val;
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [15:0] r_cs;
    logic signed [15:0] r_sn;
    logic signed [31:0] r_lox;
    logic signed [31:0] r_loy;

    // sequencer and working registers
    logic [5:0]          r_state, n_state;
    logic [5:0]          r_ret, n_ret;
    logic [GA_W-1:0]     r_clr_cnt;
    logic [2*LD_W-1:0]   r_lnum;
    logic [2*GD_W-1:0]   r_gnum;
    t_word               r_res, r_t, r_wx, r_ux1, r_uy1;
    t_word               r_minx, r_maxx, r_miny, r_maxy;
    t_word               r_dx, r_dy, r_lx, r_cx;
    logic [1:0]          r_corner;
    logic [GD_W-1:0]     r_x0, r_x1, r_y1, r_gx, r_gy;
    logic [LA_W-1:0]     r_laddr;
    logic [GA_W-1:0]     r_gaddr;
    logic signed [7:0]   r_lval;
    logic signed [7:0]   r_rdata;

    // memories
    logic [7:0] r_gmem [GLOBAL_SIDE*GLOBAL_SIDE];
    logic [7:0] r_lmem [LOCAL_SIDE*LOCAL_SIDE];

    // shared unit hookup
    t_alu_req alu_req;
    t_word    alu_a, alu_b, alu_res;
    logic     alu_done;

    // clamped dimensions and scaled constants
    logic [GD_W-1:0] gw, gh;
    logic [LD_W-1:0] lw, lh;
    t_word gres64, lres64, px64, py64, gox64, goy64, lox64, loy64, ux, uy, wy;
    t_word q0c, q1c, q2c, q3c;
    logic  box_empty, in_local, g_we, g_re;
    logic [GA_W-1:0] g_waddr;
    logic [7:0]      g_wdata;
    logic [2*LD_W-1:0] lprod;
    logic [2*GD_W-1:0] gprod;

    assign gw = (r_gwidth > 9'(GLOBAL_SIDE < 511 ? GLOBAL_SIDE : 511))
                ? GD_W'(GLOBAL_SIDE) : GD_W'(r_gwidth);
    assign gh = (r_gheight > 9'(GLOBAL_SIDE < 511 ? GLOBAL_SIDE : 511))
                ? GD_W'(GLOBAL_SIDE) : GD_W'(r_gheight);
    assign lw = (r_lwidth > 8'(LOCAL_SIDE < 255 ? LOCAL_SIDE : 255))
                ? LD_W'(LOCAL_SIDE) : LD_W'(r_lwidth);
    assign lh = (r_lheight > 8'(LOCAL_SIDE < 255 ? LOCAL_SIDE : 255))
                ? LD_W'(LOCAL_SIDE) : LD_W'(r_lheight);

    assign gres64 = (r_gres == '0) ? t_word'(1) : t_word'({1'b0, r_gres});
    assign lres64 = (r_lres == '0) ? t_word'(1) : t_word'({1'b0, r_lres});
    assign px64   = t_word'(r_px);
    assign py64   = t_word'(r_py);
    assign gox64  = t_word'(r_gorgx);
    assign goy64  = t_word'(r_gorgy);
    assign lox64  = t_word'(r_lox);
    assign loy64  = t_word'(r_loy);
    assign ux     = r_corner[0] ? r_ux1 : lox64;
    assign uy     = r_corner[1] ? r_uy1 : loy64;
    assign wy     = r_t + r_res;

    // box clipped to the grid
    assign q0c = r_minx[ALU_W-1] ? '0 : r_minx;
    assign q1c = (r_maxx > t_word'(gw) - 1) ? t_word'(gw) - 1 : r_maxx;
    assign q2c = r_miny[ALU_W-1] ? '0 : r_miny;
    assign q3c = (r_res > t_word'(gh) - 1) ? t_word'(gh) - 1 : r_res;
    assign box_empty = (q0c > q1c) || (q2c > q3c);

    // costmap cell hit test, r_res holds the row
    assign in_local = !r_cx[ALU_W-1] && (r_cx < t_word'(lw))
                   && !r_res[ALU_W-1] && (r_res < t_word'(lh));

    assign lprod = r_res[LD_W-1:0] * lw;
    assign gprod = r_gy * gw;

    crfg_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    // configuration writes
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gwidth  <= 9'd256;
            r_gheight <= 9'd256;
            r_gres    <= 31'd3277;
            r_gorgx   <= '0;
            r_gorgy   <= '0;
            r_lwidth  <= 8'd128;
            r_lheight <= 8'd128;
            r_lres    <= 31'd3277;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GWIDTH:  r_gwidth  <= i_cfg_data[8:0];
                REG_GHEIGHT: r_gheight <= i_cfg_data[8:0];
                REG_GRES:    r_gres    <= i_cfg_data[30:0];
                REG_GORGX:   r_gorgx   <= i_cfg_data;
                REG_GORGY:   r_gorgy   <= i_cfg_data;
                REG_LWIDTH:  r_lwidth  <= i_cfg_data[7:0];
                REG_LHEIGHT: r_lheight <= i_cfg_data[7:0];
                REG_LRES:    r_lres    <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // sequencer next state and unit requests
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        alu_req = '0;
        alu_a   = '0;
        alu_b   = '0;
        case (r_state)
            S_IDLE: if (start) n_state = S_PREP;
            S_PREP: begin
                case (r_cmd)
                    CMD_LOAD:  n_state = S_LOAD;
                    CMD_INTEG: n_state = I_A;
                    CMD_READ:  n_state = S_RD;
                    default:   n_state = S_CLR;
                endcase
            end
            S_LOAD: n_state = S_IDLE;
            S_RD:   n_state = (32'(r_idx) < 32'(r_gnum)) ? S_RD2 : S_IDLE;
            S_RD2:  n_state = S_IDLE;
            S_CLR:  if (r_clr_cnt == '1) n_state = S_IDLE;
            S_WAIT: if (alu_done) n_state = r_ret;
            // costmap extent
            I_A: begin
                alu_req.go = 1'b1; alu_a = lres64; alu_b = t_word'(lw);
                n_ret = I_B; n_state = S_WAIT;
            end
            I_B: begin
                alu_req.go = 1'b1; alu_a = lres64; alu_b = t_word'(lh);
                n_ret = I_C; n_state = S_WAIT;
            end
            I_C: n_state = I_D;
            // rotate one corner
            I_D: begin
                alu_req.go = 1'b1; alu_a = ux; alu_b = t_word'(r_cs);
                n_ret = I_E; n_state = S_WAIT;
            end
            I_E: begin
                alu_req.go = 1'b1; alu_a = uy; alu_b = t_word'(r_sn);
                n_ret = I_F; n_state = S_WAIT;
            end
            I_F: begin
                alu_req.go = 1'b1; alu_a = ux; alu_b = t_word'(r_sn);
                n_ret = I_G; n_state = S_WAIT;
            end
            I_G: begin
                alu_req.go = 1'b1; alu_a = uy; alu_b = t_word'(r_cs);
                n_ret = I_H; n_state = S_WAIT;
            end
            I_H: n_state = (r_corner == 2'd3) ? I_J : I_D;
            // box edges in grid cells
            I_J: begin
                alu_req.go = 1'b1; alu_req.op_div = 1'b1;
                alu_a = r_minx - (gox64 <<< 14); alu_b = gres64 <<< 14;
                n_ret = I_K; n_state = S_WAIT;
            end
            I_K: begin
                alu_req.go = 1'b1; alu_req.op_div = 1'b1;
                alu_a = r_maxx - (gox64 <<< 14); alu_b = gres64 <<< 14;
                n_ret = I_L; n_state = S_WAIT;
            end
            I_L: begin
                alu_req.go = 1'b1; alu_req.op_div = 1'b1;
                alu_a = r_miny - (goy64 <<< 14); alu_b = gres64 <<< 14;
                n_ret = I_M; n_state = S_WAIT;
            end
            I_M: begin
                alu_req.go = 1'b1; alu_req.op_div = 1'b1;
                alu_a = r_maxy - (goy64 <<< 14); alu_b = gres64 <<< 14;
                n_ret = I_N; n_state = S_WAIT;
            end
            I_N: n_state = box_empty ? S_IDLE : C_A;
            // map one grid cell centre back into the costmap
            C_A: begin
                alu_req.go = 1'b1; alu_a = gres64; alu_b = t_word'({r_gx, 1'b1});
                n_ret = C_B; n_state = S_WAIT;
            end
            C_B: begin
                alu_req.go = 1'b1; alu_a = gres64; alu_b = t_word'({r_gy, 1'b1});
                n_ret = C_C; n_state = S_WAIT;
            end
            C_C: n_state = C_D;
            C_D: begin
                alu_req.go = 1'b1; alu_a = r_dx; alu_b = t_word'(r_cs);
                n_ret = C_E; n_state = S_WAIT;
            end
            C_E: begin
                alu_req.go = 1'b1; alu_a = r_dy; alu_b = t_word'(r_sn);
                n_ret = C_F; n_state = S_WAIT;
            end
            C_F: begin
                alu_req.go = 1'b1; alu_a = r_dy; alu_b = t_word'(r_cs);
                n_ret = C_G; n_state = S_WAIT;
            end
            C_G: begin
                alu_req.go = 1'b1; alu_a = r_dx; alu_b = t_word'(r_sn);
                n_ret = C_H; n_state = S_WAIT;
            end
            C_H: begin
                alu_req.go = 1'b1; alu_req.op_div = 1'b1;
                alu_a = r_lx - (lox64 <<< 15); alu_b = lres64 <<< 15;
                n_ret = C_I; n_state = S_WAIT;
            end
            C_I: begin
                alu_req.go = 1'b1; alu_req.op_div = 1'b1;
                alu_a = r_t - (loy64 <<< 15); alu_b = lres64 <<< 15;
                n_ret = C_J; n_state = S_WAIT;
            end
            C_J: n_state = in_local ? C_K : C_N;
            C_K: n_state = C_L;
            C_L: n_state = C_N;
            C_N: begin
                if (r_gx == r_x1 && r_gy == r_y1) n_state = S_IDLE;
                else n_state = C_A;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_ret     <= S_IDLE;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            if (r_state == S_PREP) r_clr_cnt <= '0;
            else if (r_state == S_CLR) r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_cmd <= i_command;
                    r_idx <= i_cell_index;
                    r_val <= i_cell_value;
                    r_px  <= i_pose_x;
                    r_py  <= i_pose_y;
                    r_cs  <= i_pose_cos;
                    r_sn  <= i_pose_sin;
                    r_lox <= i_local_origin_x;
                    r_loy <= i_local_origin_y;
                end
            end
            S_PREP: begin
                r_lnum <= lw * lh;
                r_gnum <= gw * gh;
            end
            S_WAIT: if (alu_done) r_res <= alu_res;
            I_B: r_ux1 <= lox64 + r_res;
            I_C: begin
                r_uy1    <= loy64 + r_res;
                r_corner <= '0;
            end
            I_E: r_t  <= (px64 <<< 14) + r_res;
            I_F: r_wx <= r_t - r_res;
            I_G: r_t  <= (py64 <<< 14) + r_res;
            I_H: begin
                // running bounding box of the rotated corners
                if (r_corner == 2'd0 || r_wx < r_minx) r_minx <= r_wx;
                if (r_corner == 2'd0 || r_wx > r_maxx) r_maxx <= r_wx;
                if (r_corner == 2'd0 || wy < r_miny) r_miny <= wy;
                if (r_corner == 2'd0 || wy > r_maxy) r_maxy <= wy;
                r_corner <= r_corner + 2'd1;
            end
            I_K: r_minx <= r_res;
            I_L: r_maxx <= r_res;
            I_M: r_miny <= r_res;
            I_N: begin
                r_x0 <= GD_W'(q0c);
                r_x1 <= GD_W'(q1c);
                r_y1 <= GD_W'(q3c);
                r_gx <= GD_W'(q0c);
                r_gy <= GD_W'(q2c);
            end
            C_B: r_dx <= (gox64 <<< 1) + r_res - (px64 <<< 1);
            C_C: r_dy <= (goy64 <<< 1) + r_res - (py64 <<< 1);
            C_E: r_t  <= r_res;
            C_F: r_lx <= r_t + r_res;
            C_G: r_t  <= r_res;
            C_H: r_t  <= r_t - r_res;
            C_I: r_cx <= r_res;
            C_J: r_laddr <= LA_W'(lprod + (2*LD_W)'(r_cx[LD_W-1:0]));
            C_K: r_gaddr <= GA_W'(gprod + (2*GD_W)'(r_gx));
            C_N: begin
                if (r_gx == r_x1) begin
                    r_gx <= r_x0;
                    r_gy <= r_gy + 1'b1;
                end else begin
                    r_gx <= r_gx + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // global grid port selection
    assign g_we    = (r_state == S_CLR) || (r_state == C_L && !r_lval[7]);
    assign g_waddr = (r_state == S_CLR) ? r_clr_cnt : r_gaddr;
    assign g_wdata = (r_state == S_CLR) ? 8'hFF : r_lval;
    assign g_re    = (r_state == S_RD);

    // global grid memory
    always_ff @(posedge i_clk) begin
        if (g_we) r_gmem[g_waddr] <= g_wdata;
        if (g_re) r_rdata <= r_gmem[GA_W'(r_idx)];
    end

    // costmap memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && 32'(r_idx) < 32'(r_lnum)) r_lmem[LA_W'(r_idx)] <= r_val;
        if (r_state == C_K) r_lval <= r_lmem[r_laddr];
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = (r_state == S_RD2);
    assign o_read_value = r_rdata;

endmodule

FILE: sv/crfg_chk.sv
// port-level checker for the costmap fusion block, bound to the top level
// depends on costmap_rotate_fuse_grid_assert.svh
`include "costmap_rotate_fuse_grid_assert.svh"

module crfg_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    // every request taken while the block is idle raises busy
    `CRFG_ASSERT_NEXT(a_req_busy, start && !busy, busy)
    // a result only shows while the request is still in flight
    `CRFG_ASSERT_SAME(a_valid_busy, o_valid, busy)
    // at most one result per read, in a single cycle
    `CRFG_ASSERT_NEXT(a_valid_once, o_valid, !o_valid)
    // the block is free right after a result
    `CRFG_ASSERT_NEXT(a_valid_done, o_valid, !busy)

endmodule

bind costmap_rotate_fuse_grid crfg_chk u_crfg_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);
